// ----- hdl/rpb_pkg.sv -----
// Shared types and constants for the RGB pixel blend unit.
package rpb_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned GAIN_W      = 12;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [2:0] MODE_MULTIPLY = 3'd0;
  localparam logic [2:0] MODE_SUBTRACT = 3'd1;
  localparam logic [2:0] MODE_SCREEN   = 3'd2;
  localparam logic [2:0] MODE_OVERLAY  = 3'd3;
  localparam logic [2:0] MODE_ADD      = 3'd4;
  localparam logic [2:0] MODE_SCALE    = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADD_RED    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ADD_GREEN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ADD_BLUE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RED   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_GREEN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_BLUE  = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;

  // how the last stage forms the channel result
  typedef enum logic [1:0] {
    POST_DIRECT  = 2'd0,
    POST_DIV     = 2'd1,
    POST_DIV_INV = 2'd2,
    POST_SCALE   = 2'd3
  } post_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [PIX_W-1:0]  offs;
    logic [GAIN_W-1:0] gain;
  } chan_cfg_t;

endpackage

// ----- hdl/rpb_if.sv -----
// Request and result channel interfaces of the blend unit.
interface rpb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] a_blue;
  logic [7:0] a_green;
  logic [7:0] a_red;
  logic [7:0] b_blue;
  logic [7:0] b_green;
  logic [7:0] b_red;

  modport source (
    output valid, a_blue, a_green, a_red, b_blue, b_green, b_red,
    input  ready
  );
  modport sink (
    input  valid, a_blue, a_green, a_red, b_blue, b_green, b_red,
    output ready
  );
endinterface

interface rpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;

  modport source (
    output valid, out_blue, out_green, out_red,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red,
    output ready
  );
endinterface

// ----- hdl/rpb_chan.sv -----
// Four-stage datapath for one colour channel of the blend unit.
module rpb_chan
  import rpb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  chan_cfg_t        cfg,
  input  logic [PIX_W-1:0] a,
  input  logic [PIX_W-1:0] b,
  output logic [PIX_W-1:0] result
);

  // stage 1: operand selection and the simple modes
  logic [PIX_W-1:0]  x1_next, simple1_next;
  logic [GAIN_W-1:0] y1_next;
  logic              dbl1_next;
  post_t             post1_next;
  logic [PIX_W:0]    sum1;

  logic [PIX_W-1:0]  x1, simple1;
  logic [GAIN_W-1:0] y1;
  logic              dbl1;
  post_t             post1;

  always_comb begin
    x1_next      = a;
    y1_next      = {4'd0, b};
    dbl1_next    = 1'b0;
    post1_next   = POST_DIRECT;
    simple1_next = a;
    sum1         = {1'b0, a} + {1'b0, cfg.offs};
    case (cfg.mode)
      MODE_MULTIPLY: begin
        post1_next = POST_DIV;
      end
      MODE_SUBTRACT: begin
        simple1_next = (a > b) ? a - b : '0;
      end
      MODE_SCREEN: begin
        x1_next    = ~a;
        y1_next    = {4'd0, ~b};
        post1_next = POST_DIV_INV;
      end
      MODE_OVERLAY: begin
        dbl1_next = 1'b1;
        if (b[PIX_W-1]) begin
          x1_next    = ~a;
          y1_next    = {4'd0, ~b};
          post1_next = POST_DIV_INV;
        end else begin
          post1_next = POST_DIV;
        end
      end
      MODE_ADD: begin
        simple1_next = sum1[PIX_W] ? '1 : sum1[PIX_W-1:0];
      end
      MODE_SCALE: begin
        y1_next    = cfg.gain;
        post1_next = POST_SCALE;
      end
      default: begin
        simple1_next = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1      <= x1_next;
      y1      <= y1_next;
      dbl1    <= dbl1_next;
      post1   <= post1_next;
      simple1 <= simple1_next;
    end
  end

  // stage 2: product
  logic [19:0]      p2;
  logic             dbl2;
  post_t            post2;
  logic [PIX_W-1:0] simple2;

  always_ff @(posedge clk) begin
    if (en) begin
      p2      <= {12'd0, x1} * {8'd0, y1};
      dbl2    <= dbl1;
      post2   <= post1;
      simple2 <= simple1;
    end
  end

  // stage 3: rounding bias, quotient estimate by 257/65536, scale rounding
  logic [16:0]      n3, m3_next;
  logic [24:0]      prod3;
  logic [20:0]      sc3;
  logic [PIX_W-1:0] scl3_next;

  logic [16:0]      m3;
  logic [8:0]       est3;
  logic [PIX_W-1:0] scl3, simple3;
  post_t            post3;

  always_comb begin
    n3        = dbl2 ? {p2[15:0], 1'b0} : p2[16:0];
    m3_next   = n3 + 17'd127;
    prod3     = {m3_next, 8'd0} + {8'd0, m3_next};
    sc3       = {1'b0, p2} + 21'd128;
    scl3_next = (|sc3[20:16]) ? '1 : sc3[15:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3      <= m3_next;
      est3    <= prod3[24:16];
      scl3    <= scl3_next;
      simple3 <= simple2;
      post3   <= post2;
    end
  end

  // stage 4: estimate is at most one low, correct and select
  logic [16:0]      e255, rem4;
  logic [8:0]       q4;
  logic [PIX_W-1:0] result_next;

  always_comb begin
    e255 = {est3, 8'd0} - {8'd0, est3};
    rem4 = m3 - e255;
    q4   = est3 + {8'd0, (rem4 >= 17'd255)};
    case (post3)
      POST_DIRECT:  result_next = simple3;
      POST_DIV:     result_next = q4[PIX_W-1:0];
      POST_DIV_INV: result_next = ~q4[PIX_W-1:0];
      POST_SCALE:   result_next = scl3;
      default:      result_next = simple3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

// ----- hdl/rgb_pixel_blend_unit_core.sv -----
// An accepted request enters stage 1, then moves through the product, estimate and result registers.
// Throughput: one request per cycle while results are taken, set by the four-stage per-channel pipeline.
// A result not taken holds every stage; no request is lost or repeated.
// Reset clears the stage valid bits and loads the register defaults:
// multiply mode, zero offsets, unity gains.
// Top level of the RGB pixel blend unit.
module rgb_pixel_blend_unit_core
  import rpb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rpb_in_if.sink                 pixels,
  rpb_out_if.source              blended
);

  logic [2:0]        blend_mode;
  logic [PIX_W-1:0]  add_red, add_green, add_blue;
  logic [GAIN_W-1:0] gain_red, gain_green, gain_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_MULTIPLY;
      add_red    <= '0;
      add_green  <= '0;
      add_blue   <= '0;
      gain_red   <= GAIN_UNITY;
      gain_green <= GAIN_UNITY;
      gain_blue  <= GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE: blend_mode <= cfg_data[2:0];
        REG_ADD_RED:    add_red    <= cfg_data[PIX_W-1:0];
        REG_ADD_GREEN:  add_green  <= cfg_data[PIX_W-1:0];
        REG_ADD_BLUE:   add_blue   <= cfg_data[PIX_W-1:0];
        REG_GAIN_RED:   gain_red   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_GREEN: gain_green <= cfg_data[GAIN_W-1:0];
        REG_GAIN_BLUE:  gain_blue  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the result register is held
  logic adv;
  logic v1, v2, v3, v4;

  assign adv           = !v4 || blended.ready;
  assign pixels.ready  = adv;
  assign blended.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= pixels.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  chan_cfg_t cfg_blue, cfg_green, cfg_red;

  assign cfg_blue  = '{mode: blend_mode, offs: add_blue,  gain: gain_blue};
  assign cfg_green = '{mode: blend_mode, offs: add_green, gain: gain_green};
  assign cfg_red   = '{mode: blend_mode, offs: add_red,   gain: gain_red};

  rpb_chan u_blue (
    .clk    (clk),
    .en     (adv),
    .cfg    (cfg_blue),
    .a      (pixels.a_blue),
    .b      (pixels.b_blue),
    .result (blended.out_blue)
  );

  rpb_chan u_green (
    .clk    (clk),
    .en     (adv),
    .cfg    (cfg_green),
    .a      (pixels.a_green),
    .b      (pixels.b_green),
    .result (blended.out_green)
  );

  rpb_chan u_red (
    .clk    (clk),
    .en     (adv),
    .cfg    (cfg_red),
    .a      (pixels.a_red),
    .b      (pixels.b_red),
    .result (blended.out_red)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && pixels.ready) |=> v1)
    else $error("accepted request did not enter stage 1");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v1) && $stable(v2) && $stable(v3) && $stable(v4)))
    else $error("pipeline moved during a stall");

  a_advance_shifts: assert property (@(posedge clk) disable iff (rst)
    adv |=> (v2 == $past(v1) && v3 == $past(v2) && v4 == $past(v3)))
    else $error("valid bits lost or repeated on advance");

  a_reset_defaults: assert property (@(posedge clk)
    rst |=> (blend_mode == MODE_MULTIPLY && gain_red == GAIN_UNITY &&
             gain_green == GAIN_UNITY && gain_blue == GAIN_UNITY && !v4))
    else $error("reset defaults not loaded");

endmodule
